@@ rtl/tpg_pkg.sv @@
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared table depths, reset settings, header constants, flag positions,
// opcodes, register indices, flow states and verdict codes of the TCP port guard filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tpg_pkg;

    localparam int DEF_BLOCK_ENTRIES = 256;
    localparam int DEF_SYN_ENTRIES   = 256;
    localparam int DEF_FLOW_ENTRIES  = 1024;

    localparam logic [15:0] RST_GUARDED_PORT  = 16'd9211;
    localparam logic [31:0] RST_MIN_SYN_GAP   = 32'd10000000;
    localparam logic [15:0] RST_MAX_PAYLOAD   = 16'd1100;
    localparam logic [15:0] RST_MIN_NO_ACK    = 16'd16;

    localparam logic [15:0] HDR_BYTES         = 16'd54;
    localparam logic [15:0] ETH_IPV4          = 16'h0800;
    localparam logic [7:0]  PROTO_TCP         = 8'd6;
    localparam logic [15:0] FRAG_MF           = 16'h2000;
    localparam logic [15:0] FRAG_OFFSET       = 16'h1FFF;
    localparam logic [7:0]  AGE_MAX           = 8'd255;

    localparam int FL_FIN = 0;
    localparam int FL_SYN = 1;
    localparam int FL_RST = 2;
    localparam int FL_PSH = 3;
    localparam int FL_ACK = 4;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_ADD   = 2'd1,
        OP_DEL   = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_GUARDED_PORT = 2'd0,
        CFG_MIN_SYN_GAP  = 2'd1,
        CFG_MAX_PAYLOAD  = 2'd2,
        CFG_MIN_NO_ACK   = 2'd3
    } cfg_index_t;

    localparam logic [1:0] ST_HANDSHAKE   = 2'd1;
    localparam logic [1:0] ST_ESTABLISHED = 2'd2;
    localparam logic [1:0] ST_CLOSING     = 2'd3;

    localparam logic [3:0] R_UNFILTERED = 4'd0;
    localparam logic [3:0] R_BLOCKED    = 4'd1;
    localparam logic [3:0] R_SYN_LIMIT  = 4'd2;
    localparam logic [3:0] R_SYN_OK     = 4'd3;
    localparam logic [3:0] R_NO_FLOW    = 4'd4;
    localparam logic [3:0] R_CLOSE_DONE = 4'd5;
    localparam logic [3:0] R_HS_OK      = 4'd6;
    localparam logic [3:0] R_HS_BAD     = 4'd7;
    localparam logic [3:0] R_FRAGMENT   = 4'd8;
    localparam logic [3:0] R_TOO_LARGE  = 4'd9;
    localparam logic [3:0] R_RST        = 4'd10;
    localparam logic [3:0] R_FIN        = 4'd11;
    localparam logic [3:0] R_TOO_SMALL  = 4'd12;
    localparam logic [3:0] R_PASSED     = 4'd13;
    localparam logic [3:0] R_LIST_UPD   = 4'd14;
    localparam logic [3:0] R_LIST_FULL  = 4'd15;

endpackage

`default_nettype wire

@@ rtl/tcp_port_guard_filter.sv @@
// ----------------------------------------------------------------------------
// tcp_port_guard_filter
// Per-frame pass/drop verdicts for TCP traffic to one guarded port.
//
// Usage: each input word is a frame header summary, a block-list update or
// a no-op (valid/ready). Each gives exactly one verdict word (drop, reason,
// table_full) on the output valid/ready channel. Configuration is to be
// written through cfg_write_en/cfg_index/cfg_data only while the block is
// idle; the user must keep to this, the block itself does not enforce it.
// Block list, SYN table and flow table live in synchronous memories that
// a sequencer sweeps entry by entry (read, check).
// Unfiltered words and no-ops skip the tables; list updates and blocked
// frames sweep the block list only; other non-SYN frames also the flow table;
// SYNs the SYN table and, if accepted, it again for aging and the flow table.
// One word is in work at a time; a new word is taken as soon as the
// sequencer is idle, even while the last verdict waits in the output
// register. A stalled receiver holds the verdict and, once a second verdict
// is ready, the sequencer.
// Reset: a clearing pass over every table entry invalidates all tables;
// in_ready stays low until it ends. Configuration registers take their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_port_guard_filter #(
    parameter int BLOCK_ENTRIES = tpg_pkg::DEF_BLOCK_ENTRIES,
    parameter int SYN_ENTRIES   = tpg_pkg::DEF_SYN_ENTRIES,
    parameter int FLOW_ENTRIES  = tpg_pkg::DEF_FLOW_ENTRIES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] frame_length,
    input  wire logic [15:0] ether_type,
    input  wire logic [7:0]  ip_protocol,
    input  wire logic [31:0] source_address,
    input  wire logic [15:0] source_port,
    input  wire logic [15:0] dest_port,
    input  wire logic [5:0]  tcp_flag_bits,
    input  wire logic [15:0] fragment_word,
    input  wire logic [63:0] now_ns,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             drop,
    output logic [3:0]       reason,
    output logic             table_full,
    input  wire logic        cfg_write_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import tpg_pkg::*;

    localparam int MAXD = (BLOCK_ENTRIES > SYN_ENTRIES)
        ? ((BLOCK_ENTRIES > FLOW_ENTRIES) ? BLOCK_ENTRIES : FLOW_ENTRIES)
        : ((SYN_ENTRIES > FLOW_ENTRIES) ? SYN_ENTRIES : FLOW_ENTRIES);
    localparam int CW  = $clog2(MAXD + 1);
    localparam int BIW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
    localparam int SIW = (SYN_ENTRIES > 1) ? $clog2(SYN_ENTRIES) : 1;
    localparam int FIW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam logic [CW-1:0] BLK_LAST  = CW'(BLOCK_ENTRIES - 1);
    localparam logic [CW-1:0] SYN_LAST  = CW'(SYN_ENTRIES - 1);
    localparam logic [CW-1:0] FLOW_LAST = CW'(FLOW_ENTRIES - 1);
    localparam logic [CW-1:0] MAX_LAST  = CW'(MAXD - 1);
    localparam logic [CW-1:0] BLK_D     = CW'(BLOCK_ENTRIES);
    localparam logic [CW-1:0] SYN_D     = CW'(SYN_ENTRIES);
    localparam logic [CW-1:0] FLOW_D    = CW'(FLOW_ENTRIES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_B_RD, S_B_CHK, S_B_ACT, S_S_RD, S_S_CHK, S_S_DEC,
        S_A_RD, S_A_CHK, S_F_RD, S_F_CHK, S_F_ACT, S_DONE
    } state_t;

    // memories: block {valid, addr}; syn {valid, addr, time, age};
    // flow {valid, addr, port, state}
    logic [32:0]  blk_mem  [BLOCK_ENTRIES];
    logic [104:0] syn_mem  [SYN_ENTRIES];
    logic [50:0]  flow_mem [FLOW_ENTRIES];

    logic [32:0]  blk_rdata;
    logic [104:0] syn_rdata;
    logic [50:0]  flow_rdata;
    logic         blk_we,  syn_we,  flow_we;
    logic [BIW-1:0] blk_waddr;
    logic [SIW-1:0] syn_waddr;
    logic [FIW-1:0] flow_waddr;
    logic [32:0]  blk_wdata;
    logic [104:0] syn_wdata;
    logic [50:0]  flow_wdata;

    state_t        state_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] hit_idx_reg, free_idx_reg, max_idx_reg, sel_reg;
    logic          hit_reg, free_reg;
    logic [7:0]    max_age_reg;
    logic [63:0]   hit_time_reg;
    logic [1:0]    hit_st_reg;

    logic [15:0] guarded_port_reg, max_payload_reg, min_no_ack_reg;
    logic [31:0] min_syn_gap_reg;

    logic [1:0]  op_reg;
    logic [15:0] flen_reg, sport_reg, frag_reg;
    logic [31:0] saddr_reg;
    logic [5:0]  flags_reg;
    logic [63:0] now_reg;

    logic        res_drop_reg, res_full_reg;
    logic [3:0]  res_reason_reg;
    logic        out_valid_reg, drop_reg, full_reg;
    logic [3:0]  reason_reg;

    logic        filt;
    logic        is_syn;
    logic [15:0] payload;
    logic [7:0]  age;
    logic [CW-1:0] flow_sel;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign drop       = drop_reg;
    assign reason     = reason_reg;
    assign table_full = full_reg;

    assign filt = (opcode == OP_FRAME) && (frame_length >= HDR_BYTES)
        && (ether_type == ETH_IPV4) && (ip_protocol == PROTO_TCP)
        && (dest_port == guarded_port_reg);
    assign is_syn  = flags_reg[FL_SYN] && !flags_reg[FL_ACK];
    assign payload = flen_reg - HDR_BYTES;
    assign age     = syn_rdata[7:0];
    assign flow_sel = hit_reg ? hit_idx_reg : free_idx_reg;

    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        blk_rdata <= blk_mem[idx_reg[BIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (syn_we)
        begin
            syn_mem[syn_waddr] <= syn_wdata;
        end
        syn_rdata <= syn_mem[idx_reg[SIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (flow_we)
        begin
            flow_mem[flow_waddr] <= flow_wdata;
        end
        flow_rdata <= flow_mem[idx_reg[FIW-1:0]];
    end

    // write ports
    always_comb
    begin
        blk_we     = 1'b0;
        blk_waddr  = idx_reg[BIW-1:0];
        blk_wdata  = '0;
        syn_we     = 1'b0;
        syn_waddr  = idx_reg[SIW-1:0];
        syn_wdata  = '0;
        flow_we    = 1'b0;
        flow_waddr = idx_reg[FIW-1:0];
        flow_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                blk_we  = (idx_reg < BLK_D);
                syn_we  = (idx_reg < SYN_D);
                flow_we = (idx_reg < FLOW_D);
            end
            S_B_ACT:
            begin
                if (op_reg == OP_ADD && !hit_reg && free_reg)
                begin
                    blk_we    = 1'b1;
                    blk_waddr = free_idx_reg[BIW-1:0];
                    blk_wdata = {1'b1, saddr_reg};
                end
                else if (op_reg == OP_DEL && hit_reg)
                begin
                    blk_we    = 1'b1;
                    blk_waddr = hit_idx_reg[BIW-1:0];
                end
            end
            S_A_CHK:
            begin
                // age every valid entry, refresh the chosen one
                syn_we = 1'b1;
                if (idx_reg == sel_reg)
                begin
                    syn_wdata = {1'b1, saddr_reg, now_reg, 8'd0};
                end
                else if (syn_rdata[104] && age != AGE_MAX)
                begin
                    syn_wdata = {syn_rdata[104:8], age + 8'd1};
                end
                else
                begin
                    syn_wdata = syn_rdata;
                end
            end
            S_F_ACT:
            begin
                flow_waddr = flow_sel[FIW-1:0];
                if (is_syn)
                begin
                    flow_we    = hit_reg || free_reg;
                    flow_wdata = {1'b1, saddr_reg, sport_reg, ST_HANDSHAKE};
                end
                else if (hit_reg)
                begin
                    flow_wdata = {1'b1, saddr_reg, sport_reg, hit_st_reg};
                    if (hit_st_reg == ST_CLOSING && !flags_reg[FL_ACK])
                    begin
                        flow_we    = 1'b1;
                        flow_wdata = '0;
                    end
                    else if (hit_st_reg == ST_HANDSHAKE)
                    begin
                        if (flags_reg[FL_ACK] && !flags_reg[FL_PSH]
                            && !flags_reg[FL_FIN] && !flags_reg[FL_RST])
                        begin
                            flow_we    = 1'b1;
                            flow_wdata = {1'b1, saddr_reg, sport_reg, ST_ESTABLISHED};
                        end
                    end
                    else if ((frag_reg & (FRAG_MF | FRAG_OFFSET)) != 16'd0
                             || payload > max_payload_reg)
                    begin
                        flow_we = 1'b0;
                    end
                    else if (flags_reg[FL_RST])
                    begin
                        flow_we    = 1'b1;
                        flow_wdata = '0;
                    end
                    else if (flags_reg[FL_FIN])
                    begin
                        flow_we    = 1'b1;
                        flow_wdata = {1'b1, saddr_reg, sport_reg, ST_CLOSING};
                    end
                end
            end
            default:
            begin
                blk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            idx_reg          <= '0;
            out_valid_reg    <= 1'b0;
            guarded_port_reg <= RST_GUARDED_PORT;
            min_syn_gap_reg  <= RST_MIN_SYN_GAP;
            max_payload_reg  <= RST_MAX_PAYLOAD;
            min_no_ack_reg   <= RST_MIN_NO_ACK;
            hit_reg          <= 1'b0;
            free_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_GUARDED_PORT: guarded_port_reg <= cfg_data[15:0];
                    CFG_MIN_SYN_GAP:  min_syn_gap_reg  <= cfg_data;
                    CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_data[15:0];
                    CFG_MIN_NO_ACK:   min_no_ack_reg   <= cfg_data[15:0];
                    default:          min_no_ack_reg   <= min_no_ack_reg;
                endcase
            end

            // a verdict loaded in S_DONE takes the register over
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    if (idx_reg == MAX_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg     <= opcode;
                        flen_reg   <= frame_length;
                        saddr_reg  <= source_address;
                        sport_reg  <= source_port;
                        flags_reg  <= tcp_flag_bits;
                        frag_reg   <= fragment_word;
                        now_reg    <= now_ns;
                        idx_reg    <= '0;
                        hit_reg    <= 1'b0;
                        free_reg   <= 1'b0;
                        res_drop_reg   <= 1'b0;
                        res_full_reg   <= 1'b0;
                        res_reason_reg <= R_UNFILTERED;
                        if (opcode == OP_NOP || (opcode == OP_FRAME && !filt))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_B_RD;
                        end
                    end
                end
                S_B_RD:
                begin
                    state_reg <= S_B_CHK;
                end
                S_B_CHK:
                begin
                    if (blk_rdata[32] && blk_rdata[31:0] == saddr_reg && !hit_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= idx_reg;
                    end
                    if (!blk_rdata[32] && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                    if (idx_reg == BLK_LAST)
                    begin
                        state_reg <= S_B_ACT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_B_RD;
                    end
                end
                S_B_ACT:
                begin
                    idx_reg     <= '0;
                    hit_reg     <= 1'b0;
                    free_reg    <= 1'b0;
                    max_age_reg <= '0;
                    max_idx_reg <= '0;
                    if (op_reg != OP_FRAME)
                    begin
                        if (op_reg == OP_ADD && !hit_reg && !free_reg)
                        begin
                            res_reason_reg <= R_LIST_FULL;
                            res_full_reg   <= 1'b1;
                        end
                        else
                        begin
                            res_reason_reg <= R_LIST_UPD;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (hit_reg)
                    begin
                        res_drop_reg   <= 1'b1;
                        res_reason_reg <= R_BLOCKED;
                        state_reg      <= S_DONE;
                    end
                    else if (is_syn)
                    begin
                        state_reg <= S_S_RD;
                    end
                    else
                    begin
                        state_reg <= S_F_RD;
                    end
                end
                S_S_RD:
                begin
                    state_reg <= S_S_CHK;
                end
                S_S_CHK:
                begin
                    if (syn_rdata[104] && syn_rdata[103:72] == saddr_reg && !hit_reg)
                    begin
                        hit_reg      <= 1'b1;
                        hit_idx_reg  <= idx_reg;
                        hit_time_reg <= syn_rdata[71:8];
                    end
                    if (!syn_rdata[104] && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                    if (age > max_age_reg)
                    begin
                        max_age_reg <= age;
                        max_idx_reg <= idx_reg;
                    end
                    if (idx_reg == SYN_LAST)
                    begin
                        state_reg <= S_S_DEC;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_S_RD;
                    end
                end
                S_S_DEC:
                begin
                    if (hit_reg && (now_reg - hit_time_reg) < {32'd0, min_syn_gap_reg})
                    begin
                        res_drop_reg   <= 1'b1;
                        res_reason_reg <= R_SYN_LIMIT;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        sel_reg   <= hit_reg ? hit_idx_reg
                                   : (free_reg ? free_idx_reg : max_idx_reg);
                        idx_reg   <= '0;
                        state_reg <= S_A_RD;
                    end
                end
                S_A_RD:
                begin
                    state_reg <= S_A_CHK;
                end
                S_A_CHK:
                begin
                    if (idx_reg == SYN_LAST)
                    begin
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        state_reg <= S_F_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_A_RD;
                    end
                end
                S_F_RD:
                begin
                    state_reg <= S_F_CHK;
                end
                S_F_CHK:
                begin
                    if (flow_rdata[50] && flow_rdata[49:18] == saddr_reg
                        && flow_rdata[17:2] == sport_reg && !hit_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= idx_reg;
                        hit_st_reg  <= flow_rdata[1:0];
                    end
                    if (!flow_rdata[50] && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                    if (idx_reg == FLOW_LAST)
                    begin
                        state_reg <= S_F_ACT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_F_RD;
                    end
                end
                S_F_ACT:
                begin
                    state_reg <= S_DONE;
                    if (is_syn)
                    begin
                        res_reason_reg <= R_SYN_OK;
                        res_full_reg   <= !hit_reg && !free_reg;
                    end
                    else if (!hit_reg)
                    begin
                        res_drop_reg   <= 1'b1;
                        res_reason_reg <= R_NO_FLOW;
                    end
                    else if (hit_st_reg == ST_CLOSING && !flags_reg[FL_ACK])
                    begin
                        res_reason_reg <= R_CLOSE_DONE;
                    end
                    else if (hit_st_reg == ST_HANDSHAKE)
                    begin
                        if (flags_reg[FL_ACK] && !flags_reg[FL_PSH]
                            && !flags_reg[FL_FIN] && !flags_reg[FL_RST])
                        begin
                            res_reason_reg <= R_HS_OK;
                        end
                        else
                        begin
                            res_drop_reg   <= 1'b1;
                            res_reason_reg <= R_HS_BAD;
                        end
                    end
                    else if ((frag_reg & (FRAG_MF | FRAG_OFFSET)) != 16'd0)
                    begin
                        res_drop_reg   <= 1'b1;
                        res_reason_reg <= R_FRAGMENT;
                    end
                    else if (payload > max_payload_reg)
                    begin
                        res_drop_reg   <= 1'b1;
                        res_reason_reg <= R_TOO_LARGE;
                    end
                    else if (flags_reg[FL_RST])
                    begin
                        res_reason_reg <= R_RST;
                    end
                    else if (flags_reg[FL_FIN])
                    begin
                        res_reason_reg <= R_FIN;
                    end
                    else if (!flags_reg[FL_ACK] && payload < min_no_ack_reg)
                    begin
                        res_drop_reg   <= 1'b1;
                        res_reason_reg <= R_TOO_SMALL;
                    end
                    else
                    begin
                        res_reason_reg <= R_PASSED;
                    end
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        drop_reg      <= res_drop_reg;
                        reason_reg    <= res_reason_reg;
                        full_reg      <= res_full_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tpg_verdict_checker.sv @@
// ----------------------------------------------------------------------------
// tpg_verdict_checker
// Watches the word and verdict channels and the register port of the TCP port
// guard filter, keeps its own copy of the block list, SYN table and flow
// table, predicts one verdict per accepted word and compares it with the
// verdicts that leave the block, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module tpg_verdict_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] frame_length,
    input  wire logic [15:0] ether_type,
    input  wire logic [7:0]  ip_protocol,
    input  wire logic [31:0] source_address,
    input  wire logic [15:0] source_port,
    input  wire logic [15:0] dest_port,
    input  wire logic [5:0]  tcp_flag_bits,
    input  wire logic [15:0] fragment_word,
    input  wire logic [63:0] now_ns,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        drop,
    input  wire logic [3:0]  reason,
    input  wire logic        table_full,
    input  wire logic        cfg_write_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               errors,
    output int               pending
);

    import tpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = DEF_BLOCK_ENTRIES;
    localparam int NS = DEF_SYN_ENTRIES;
    localparam int NF = DEF_FLOW_ENTRIES;

    typedef struct packed {
        logic       drop;
        logic [3:0] reason;
        logic       full;
    } verdict_t;

    verdict_t verdicts_due[$];
    int       mismatches;

    logic [15:0] guard_port;
    logic [31:0] syn_gap;
    logic [15:0] max_pay;
    logic [15:0] min_no_ack;

    logic        blk_v [NB];
    logic [31:0] blk_a [NB];
    logic        syn_v [NS];
    logic [31:0] syn_a [NS];
    logic [63:0] syn_t [NS];
    logic [7:0]  syn_age [NS];
    logic        flow_v [NF];
    logic [31:0] flow_a [NF];
    logic [15:0] flow_p [NF];
    logic [1:0]  flow_st [NF];

    assign errors  = mismatches;
    assign pending = verdicts_due.size();

    function automatic int find_blocked(logic [31:0] a);
        for (int i = 0; i < NB; i++)
            if (blk_v[i] && blk_a[i] == a)
                return i;
        return -1;
    endfunction

    function automatic int find_source(logic [31:0] a);
        for (int i = 0; i < NS; i++)
            if (syn_v[i] && syn_a[i] == a)
                return i;
        return -1;
    endfunction

    function automatic int find_flow(logic [31:0] a, logic [15:0] p);
        for (int i = 0; i < NF; i++)
            if (flow_v[i] && flow_a[i] == a && flow_p[i] == p)
                return i;
        return -1;
    endfunction

    // Refresh or place a source: first free slot, else the oldest, lowest index.
    function automatic void stamp_syn(logic [31:0] a, logic [63:0] t);
        int k;
        k = find_source(a);
        if (k < 0)
            for (int i = 0; i < NS && k < 0; i++)
                if (!syn_v[i])
                    k = i;
        if (k < 0)
        begin
            k = 0;
            for (int i = 1; i < NS; i++)
                if (syn_age[i] > syn_age[k])
                    k = i;
        end
        for (int i = 0; i < NS; i++)
            if (i != k && syn_v[i] && syn_age[i] != AGE_MAX)
                syn_age[i]++;
        syn_v[k]   = 1'b1;
        syn_a[k]   = a;
        syn_t[k]   = t;
        syn_age[k] = '0;
    endfunction

    function automatic verdict_t judge_word();
        verdict_t    v;
        opcode_t     op;
        int          k;
        logic [15:0] payload;
        logic        fin, syn, rst, psh, ack;
        v   = '0;
        op  = opcode_t'(opcode);
        fin = tcp_flag_bits[FL_FIN];
        syn = tcp_flag_bits[FL_SYN];
        rst = tcp_flag_bits[FL_RST];
        psh = tcp_flag_bits[FL_PSH];
        ack = tcp_flag_bits[FL_ACK];
        if (op == OP_ADD)
        begin
            v.reason = R_LIST_UPD;
            if (find_blocked(source_address) < 0)
            begin
                k = -1;
                for (int i = 0; i < NB && k < 0; i++)
                    if (!blk_v[i])
                        k = i;
                if (k < 0)
                begin
                    v.reason = R_LIST_FULL;
                    v.full   = 1'b1;
                end
                else
                begin
                    blk_v[k] = 1'b1;
                    blk_a[k] = source_address;
                end
            end
        end
        else if (op == OP_DEL)
        begin
            k = find_blocked(source_address);
            if (k >= 0)
                blk_v[k] = 1'b0;
            v.reason = R_LIST_UPD;
        end
        else if (op == OP_FRAME && frame_length >= HDR_BYTES && ether_type == ETH_IPV4
                 && ip_protocol == PROTO_TCP && dest_port == guard_port)
        begin
            if (find_blocked(source_address) >= 0)
            begin
                v.drop   = 1'b1;
                v.reason = R_BLOCKED;
            end
            else if (syn && !ack)
            begin
                k = find_source(source_address);
                if (k >= 0 && (now_ns - syn_t[k]) < {32'd0, syn_gap})
                begin
                    v.drop   = 1'b1;
                    v.reason = R_SYN_LIMIT;
                end
                else
                begin
                    stamp_syn(source_address, now_ns);
                    v.reason = R_SYN_OK;
                    k = find_flow(source_address, source_port);
                    for (int i = 0; i < NF && k < 0; i++)
                        if (!flow_v[i])
                            k = i;
                    if (k < 0)
                        v.full = 1'b1;
                    else
                    begin
                        flow_v[k]  = 1'b1;
                        flow_a[k]  = source_address;
                        flow_p[k]  = source_port;
                        flow_st[k] = ST_HANDSHAKE;
                    end
                end
            end
            else
            begin
                k       = find_flow(source_address, source_port);
                payload = frame_length - HDR_BYTES;
                v.drop  = 1'b1;
                if (k < 0)
                    v.reason = R_NO_FLOW;
                else if (flow_st[k] == ST_CLOSING && !ack)
                begin
                    flow_v[k] = 1'b0;
                    v.drop    = 1'b0;
                    v.reason  = R_CLOSE_DONE;
                end
                else if (flow_st[k] == ST_HANDSHAKE)
                begin
                    if (ack && !psh && !fin && !rst)
                    begin
                        flow_st[k] = ST_ESTABLISHED;
                        v.drop     = 1'b0;
                        v.reason   = R_HS_OK;
                    end
                    else
                        v.reason = R_HS_BAD;
                end
                else if ((fragment_word & (FRAG_MF | FRAG_OFFSET)) != 0)
                    v.reason = R_FRAGMENT;
                else if (payload > max_pay)
                    v.reason = R_TOO_LARGE;
                else if (rst)
                begin
                    flow_v[k] = 1'b0;
                    v.drop    = 1'b0;
                    v.reason  = R_RST;
                end
                else if (fin)
                begin
                    flow_st[k] = ST_CLOSING;
                    v.drop     = 1'b0;
                    v.reason   = R_FIN;
                end
                else if (!ack && payload < min_no_ack)
                    v.reason = R_TOO_SMALL;
                else
                begin
                    v.drop   = 1'b0;
                    v.reason = R_PASSED;
                end
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            guard_port = RST_GUARDED_PORT;
            syn_gap    = RST_MIN_SYN_GAP;
            max_pay    = RST_MAX_PAYLOAD;
            min_no_ack = RST_MIN_NO_ACK;
            foreach (blk_v[i])
                blk_v[i] = 1'b0;
            foreach (syn_v[i])
            begin
                syn_v[i]   = 1'b0;
                syn_age[i] = '0;
            end
            foreach (flow_v[i])
                flow_v[i] = 1'b0;
            verdicts_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_write_en)
                case (cfg_index_t'(cfg_index))
                    CFG_GUARDED_PORT: guard_port = cfg_data[15:0];
                    CFG_MIN_SYN_GAP:  syn_gap    = cfg_data;
                    CFG_MAX_PAYLOAD:  max_pay    = cfg_data[15:0];
                    CFG_MIN_NO_ACK:   min_no_ack = cfg_data[15:0];
                    default:          ;
                endcase
            if (in_valid && in_ready)
                verdicts_due.push_back(judge_word());
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: verdict with none due: drop %0d reason %0d full %0d",
                                 $time, drop, reason, table_full);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (want.drop !== drop || want.reason !== reason
                        || want.full !== table_full)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: verdict mismatch: drop exp %0d act %0d, ",
                                      "reason exp %0d act %0d, full exp %0d act %0d"},
                                     $time, want.drop, drop, want.reason, reason,
                                     want.full, table_full);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tcp_port_guard_filter_test.sv @@
// ----------------------------------------------------------------------------
// tcp_port_guard_filter_test
// Drives header words, block-list updates and register writes into the TCP
// port guard filter: a directed opening, a block list fill-up, SYN table
// eviction, and random TCP sessions mixed with noise under four register
// settings, with random idling on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_port_guard_filter_test;

    import tpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int     DRAIN_WAIT  = 4000;

    localparam logic [5:0] B_FIN = 6'd1 << FL_FIN;
    localparam logic [5:0] B_SYN = 6'd1 << FL_SYN;
    localparam logic [5:0] B_RST = 6'd1 << FL_RST;
    localparam logic [5:0] B_PSH = 6'd1 << FL_PSH;
    localparam logic [5:0] B_ACK = 6'd1 << FL_ACK;

    typedef struct {
        opcode_t     op;
        logic [15:0] len;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [31:0] saddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [5:0]  flags;
        logic [15:0] frag;
        logic [63:0] now;
    } header_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [5:0]  tcp_flag_bits;
    logic [15:0] fragment_word;
    logic [63:0] now_ns;
    logic        out_valid;
    logic        out_ready;
    logic        drop;
    logic [3:0]  reason;
    logic        table_full;
    logic        cfg_write_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;

    logic        calm;
    logic        rx_hold_req;
    logic [63:0] clock_ns;
    logic [15:0] cur_port;
    logic [31:0] cur_gap;
    logic [15:0] cur_max_pay;
    logic [15:0] cur_min_no_ack;
    int          random_sent;

    tcp_port_guard_filter i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .frame_length   (frame_length),
        .ether_type     (ether_type),
        .ip_protocol    (ip_protocol),
        .source_address (source_address),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .tcp_flag_bits  (tcp_flag_bits),
        .fragment_word  (fragment_word),
        .now_ns         (now_ns),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drop           (drop),
        .reason         (reason),
        .table_full     (table_full),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    tpg_verdict_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .frame_length   (frame_length),
        .ether_type     (ether_type),
        .ip_protocol    (ip_protocol),
        .source_address (source_address),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .tcp_flag_bits  (tcp_flag_bits),
        .fragment_word  (fragment_word),
        .now_ns         (now_ns),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drop           (drop),
        .reason         (reason),
        .table_full     (table_full),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .pending        (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tcp_port_guard_filter regression: fail");
        $finish;
    end

    // Receiver: random stalls, or one long hold-off when asked.
    initial
    begin
        logic held;
        out_ready = 1'b0;
        held      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req && !held)
            begin
                out_ready = 1'b0;
                repeat (20000) @(negedge clk);
                held = 1'b1;
            end
            out_ready = calm || ($urandom_range(0, 99) >= 17);
        end
    end

    task automatic offer(header_word_t w);
        if (!calm)
            while ($urandom_range(0, 99) < 17)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        opcode         = w.op;
        frame_length   = w.len;
        ether_type     = w.etype;
        ip_protocol    = w.proto;
        source_address = w.saddr;
        source_port    = w.sport;
        dest_port      = w.dport;
        tcp_flag_bits  = w.flags;
        fragment_word  = w.frag;
        now_ns         = w.now;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic settle();
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = value;
        @(negedge clk);
        cfg_write_en = 1'b0;
        case (idx)
            CFG_GUARDED_PORT: cur_port       = value[15:0];
            CFG_MIN_SYN_GAP:  cur_gap        = value;
            CFG_MAX_PAYLOAD:  cur_max_pay    = value[15:0];
            CFG_MIN_NO_ACK:   cur_min_no_ack = value[15:0];
            default:          ;
        endcase
    endtask

    task automatic write_all(logic [15:0] port, logic [31:0] gap, logic [15:0] mx,
                             logic [15:0] mn);
        settle();
        write_reg(CFG_GUARDED_PORT, {16'd0, port});
        write_reg(CFG_MIN_SYN_GAP, gap);
        write_reg(CFG_MAX_PAYLOAD, {16'd0, mx});
        write_reg(CFG_MIN_NO_ACK, {16'd0, mn});
    endtask

    // Well-formed guarded segment at the current time.
    function automatic header_word_t segment(logic [31:0] a, logic [15:0] p,
                                             logic [5:0] f, logic [15:0] len,
                                             logic [15:0] frag);
        header_word_t w;
        w.op    = OP_FRAME;
        w.len   = len;
        w.etype = ETH_IPV4;
        w.proto = PROTO_TCP;
        w.saddr = a;
        w.sport = p;
        w.dport = cur_port;
        w.flags = f;
        w.frag  = frag;
        w.now   = clock_ns;
        return w;
    endfunction

    function automatic header_word_t list_op(opcode_t op, logic [31:0] a);
        header_word_t w;
        w       = segment(a, 16'd0, 6'd0, 16'd0, 16'd0);
        w.op    = op;
        w.saddr = a;
        return w;
    endfunction

    function automatic logic [15:0] pick_len();
        int p;
        case ($urandom_range(0, 3))
            0:       p = int'(cur_max_pay) + $urandom_range(0, 4) - 2;
            1:       p = int'(cur_min_no_ack) + $urandom_range(0, 4) - 2;
            default: p = $urandom_range(0, 60);
        endcase
        if (p < 0)
            p = 0;
        if (p > 65535 - 54)
            p = 65535 - 54;
        return 16'(p + 54);
    endfunction

    function automatic logic [15:0] pick_frag();
        case ($urandom_range(0, 9))
            0:       return FRAG_MF;
            1:       return 16'($urandom_range(1, 16'h1FFF));
            2:       return 16'h4000;
            default: return 16'h0000;
        endcase
    endfunction

    // Advance time, mostly past the SYN gap, sometimes by no more than 1000 ns.
    task automatic tick();
        if ($urandom_range(0, 3) == 0)
            clock_ns += 64'($urandom_range(0, 1000));
        else
            clock_ns += {32'd0, cur_gap} + 64'($urandom_range(0, 1000));
    endtask

    function automatic logic [31:0] pool_addr();
        return 32'hC0A8_0100 + $urandom_range(0, 7);
    endfunction

    task automatic run_session();
        logic [31:0] a;
        logic [15:0] p;
        logic [5:0]  f;
        int          n;
        a = pool_addr();
        p = 16'(1000 + $urandom_range(0, 3));
        tick();
        f = B_SYN | (6'($urandom) & ~B_ACK);
        offer(segment(a, p, f, pick_len(), 16'd0));
        f = B_ACK;
        if ($urandom_range(0, 9) == 0)
            f = f | B_PSH;
        tick();
        offer(segment(a, p, f, pick_len(), 16'd0));
        random_sent += 2;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            f = 6'($urandom) & (B_ACK | B_PSH | 6'b100000);
            if ($urandom_range(0, 3) != 0)
                f = f | B_ACK;
            tick();
            offer(segment(a, p, f, pick_len(), pick_frag()));
            random_sent++;
        end
        case ($urandom_range(0, 3))
            0, 1:
            begin
                offer(segment(a, p, B_FIN | B_ACK, pick_len(), 16'd0));
                offer(segment(a, p, 6'($urandom) & ~B_ACK & ~B_SYN, pick_len(),
                              pick_frag()));
                random_sent += 2;
            end
            2:
            begin
                offer(segment(a, p, B_RST | (6'($urandom) & B_FIN), pick_len(), 16'd0));
                random_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic run_phase(int quota);
        header_word_t w;
        int           r;
        quota += random_sent;
        while (random_sent < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                run_session();
            else if (r < 80)
            begin
                w.op    = opcode_t'($urandom_range(0, 3));
                w.len   = 16'($urandom);
                w.etype = $urandom_range(0, 1) ? ETH_IPV4 : 16'($urandom);
                w.proto = $urandom_range(0, 1) ? PROTO_TCP : 8'($urandom);
                w.saddr = $urandom_range(0, 1) ? pool_addr() : 32'($urandom);
                w.sport = $urandom_range(0, 1) ? 16'(1000 + $urandom_range(0, 3))
                                                : 16'($urandom);
                w.dport = $urandom_range(0, 1) ? cur_port : 16'($urandom);
                w.flags = 6'($urandom);
                w.frag  = 16'($urandom);
                w.now   = $urandom_range(0, 3) == 0 ? {32'($urandom), 32'($urandom)}
                                                    : clock_ns;
                offer(w);
                random_sent++;
            end
            else if (r < 88)
            begin
                offer(list_op($urandom_range(0, 1) ? OP_ADD : OP_DEL, pool_addr()));
                random_sent++;
            end
            else
            begin
                tick();
                offer(segment(pool_addr(), 16'(1000 + $urandom_range(0, 3)),
                              6'($urandom), pick_len(), pick_frag()));
                random_sent++;
            end
        end
    endtask

    initial
    begin
        logic [31:0] a_blk, b_src, e_src;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = '0;
        frame_length   = '0;
        ether_type     = '0;
        ip_protocol    = '0;
        source_address = '0;
        source_port    = '0;
        dest_port      = '0;
        tcp_flag_bits  = '0;
        fragment_word  = '0;
        now_ns         = '0;
        cfg_write_en   = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        calm           = 1'b0;
        rx_hold_req    = 1'b0;
        random_sent    = 0;
        cur_port       = RST_GUARDED_PORT;
        cur_gap        = RST_MIN_SYN_GAP;
        cur_max_pay    = RST_MAX_PAYLOAD;
        cur_min_no_ack = RST_MIN_NO_ACK;
        clock_ns       = 64'd1_000_000_000;
        a_blk          = 32'h0A00_0001;
        b_src          = 32'h0A00_0002;
        e_src          = 32'h0A00_0005;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed opening at reset settings: filter gates first.
        offer(segment(b_src, 16'd1, B_ACK, 16'd53, 16'd0));
        begin
            header_word_t w;
            w = segment(b_src, 16'd1, B_ACK, 16'd54, 16'd0);
            w.etype = 16'h86DD;
            offer(w);
            w = segment(b_src, 16'd1, B_ACK, 16'd54, 16'd0);
            w.proto = 8'd17;
            offer(w);
            w = segment(b_src, 16'd1, B_ACK, 16'd54, 16'd0);
            w.dport = cur_port + 16'd1;
            offer(w);
            w = segment(b_src, 16'd1, B_SYN, 16'd54, 16'd0);
            w.op = OP_NOP;
            offer(w);
        end
        offer(list_op(OP_ADD, a_blk));
        offer(list_op(OP_ADD, a_blk));
        offer(segment(a_blk, 16'd7, B_SYN, 16'd54, 16'd0));
        offer(list_op(OP_DEL, a_blk));
        offer(list_op(OP_DEL, a_blk));
        // Handshake and the segment rules on one flow.
        offer(segment(b_src, 16'd1, B_SYN, 16'd60, 16'd0));
        offer(segment(b_src, 16'd2, B_SYN, 16'd60, 16'd0));
        offer(segment(b_src, 16'd1, B_ACK, 16'd54, 16'd0));
        offer(segment(b_src, 16'd3, B_ACK, 16'd54, 16'd0));
        offer(segment(b_src, 16'd1, B_ACK, 16'd54, FRAG_MF));
        offer(segment(b_src, 16'd1, B_ACK, 16'd54, 16'h1FFF));
        offer(segment(b_src, 16'd1, B_ACK, 16'd54 + 16'd1101, 16'd0));
        offer(segment(b_src, 16'd1, B_PSH, 16'd54 + 16'd15, 16'd0));
        offer(segment(b_src, 16'd1, B_PSH, 16'd54 + 16'd16, 16'd0));
        offer(segment(b_src, 16'd1, B_FIN | B_ACK, 16'd54 + 16'd1100, 16'd0));
        offer(segment(b_src, 16'd1, B_ACK, 16'd54, 16'd0));
        offer(segment(b_src, 16'd1, B_PSH, 16'd54, 16'd0));
        // RST beats FIN; a pushed ACK spoils the handshake.
        clock_ns += 64'd20_000_000;
        offer(segment(b_src, 16'd4, B_SYN, 16'd54, 16'd0));
        offer(segment(b_src, 16'd4, B_ACK, 16'd54, 16'd0));
        offer(segment(b_src, 16'd4, B_RST | B_FIN | B_ACK, 16'd54, 16'd0));
        offer(segment(e_src, 16'd1, B_SYN, 16'd54, 16'd0));
        offer(segment(e_src, 16'd1, B_ACK | B_PSH, 16'd54, 16'd0));
        // SYN gap measured across the wrap of the time counter.
        clock_ns = 64'hFFFF_FFFF_FFFF_FFFB;
        offer(segment(32'h0A00_0006, 16'd1, B_SYN, 16'd54, 16'd0));
        clock_ns = 64'd3;
        offer(segment(32'h0A00_0006, 16'd1, B_SYN, 16'd54, 16'd0));
        clock_ns = 64'd2_000_000_000;

        // Fill the block list, overflow it, then free a few entries again.
        for (int i = 0; i < DEF_BLOCK_ENTRIES; i++)
            offer(list_op(OP_ADD, 32'h0C00_0000 + i));
        offer(list_op(OP_ADD, 32'h0CFF_FFFF));
        offer(segment(32'h0C00_0011, 16'd1, B_ACK, 16'd54, 16'd0));
        for (int i = 0; i < 16; i++)
            offer(list_op(OP_DEL, 32'h0C00_0000 + i));

        // Random sessions and noise, one register setting per phase.
        settle();
        run_phase(60);
        calm = 1'b1;
        run_phase(40);
        calm = 1'b0;
        // Long receiver hold-off while words keep coming; then drain fully.
        rx_hold_req = 1'b1;
        repeat (8)
        begin
            header_word_t w;
            w = segment(pool_addr(), 16'd1000, B_ACK, 16'd54, 16'd0);
            w.dport = cur_port + 16'd1;
            offer(w);
        end
        write_all(16'hFFFF, 32'd0, 16'hFFFF, 16'd0);
        run_phase(60);
        write_all(16'h0000, 32'd1000, 16'h0000, 16'hFFFF);
        run_phase(60);
        write_all(16'($urandom), 32'($urandom_range(0, 50_000_000)),
                  16'($urandom_range(0, 1500)), 16'($urandom_range(0, 64)));
        run_phase(60);

        // Distinct sources push the SYN table past LRU eviction.
        write_all(RST_GUARDED_PORT, 32'd0, RST_MAX_PAYLOAD, RST_MIN_NO_ACK);
        for (int i = 0; i < DEF_SYN_ENTRIES + 4; i++)
        begin
            clock_ns += 64'd1;
            offer(segment(32'h0B00_0000 + i, 16'd5, B_SYN, 16'd54, 16'd0));
        end
        write_all(RST_GUARDED_PORT, 32'hFFFF_FFFF, RST_MAX_PAYLOAD, RST_MIN_NO_ACK);
        offer(segment(32'h0B00_0000 + DEF_SYN_ENTRIES + 3, 16'd6, B_SYN, 16'd54, 16'd0));
        offer(segment(32'h0B00_0000, 16'd6, B_SYN, 16'd54, 16'd0));

        settle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tcp_port_guard_filter regression: pass");
        else
            $display("tcp_port_guard_filter regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ tcp_port_guard_filter.f @@
rtl/tpg_pkg.sv
rtl/tcp_port_guard_filter.sv
tb/sv/tpg_verdict_checker.sv
tb/sv/tcp_port_guard_filter_test.sv
